>>> sv/kmst_pkg.sv
package kmst_pkg;

  localparam int DEF_MAX_EDGES    = 256;
  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_WEIGHT_BITS  = 16;

  localparam int VERT_BITS  = 8;
  localparam int IN_W_BITS  = 16;
  localparam int COST_BITS  = 24;
  localparam int TAKE_BITS  = 8;
  localparam int RANK_BITS  = 4;
  localparam int SUM_BITS   = 34;

  localparam logic [SUM_BITS-1:0] COST_MAX = SUM_BITS'(64'sd8388607);
  localparam logic [SUM_BITS-1:0] COST_MIN = SUM_BITS'(-64'sd8388608);
  localparam logic [RANK_BITS-1:0] RANK_TOP = '1;
  localparam logic [TAKE_BITS-1:0] TAKE_TOP = '1;

  typedef struct packed {
    logic [VERT_BITS-1:0] parent;
    logic [RANK_BITS-1:0] rank;
  } uf_entry_t;

endpackage

>>> sv/kruskal_mst_cost.sv
// Loading stores one edge word per cycle while in_valid is high. After the last edge the pass
// runs repeated selection scans over the edge memory; for each selected edge with both ends in
// range it walks the root chain of each end in the union-find memory and, if the roots differ,
// writes the union (a second write bumps a rank when ranks are equal), then posts the result.
// One graph is handled per pass; input is not ready while a pass runs.
// Reset (rst_n, synchronous): edge count, union-find valid bits and the
// sequencer clear at once; no clearing sweep is needed.
module kruskal_mst_cost #(
  parameter int MAX_EDGES    = kmst_pkg::DEF_MAX_EDGES,
  parameter int MAX_VERTICES = kmst_pkg::DEF_MAX_VERTICES,
  parameter int WEIGHT_BITS  = kmst_pkg::DEF_WEIGHT_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [kmst_pkg::VERT_BITS-1:0]       in_vertex_a,
  input  logic [kmst_pkg::VERT_BITS-1:0]       in_vertex_b,
  input  logic signed [kmst_pkg::IN_W_BITS-1:0] in_weight,
  input  logic                                 in_last_edge,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [kmst_pkg::COST_BITS-1:0] out_total_cost,
  output logic [kmst_pkg::TAKE_BITS-1:0]       out_edges_taken
);
  import kmst_pkg::*;

  // Geometry: the union-find only needs vertices an 8-bit index can reach.
  localparam int EAW  = $clog2(MAX_EDGES);
  localparam int CW   = $clog2(MAX_EDGES + 1);
  localparam int UFD  = (MAX_VERTICES < 256) ? MAX_VERTICES : 256;
  localparam int UFAW = $clog2(UFD);
  localparam int EW   = 2 * VERT_BITS + WEIGHT_BITS;
  localparam int KW   = WEIGHT_BITS + EAW;
  localparam int UW   = VERT_BITS + RANK_BITS;

  localparam logic [3:0] S_LOAD   = 4'd0;
  localparam logic [3:0] S_SCAN   = 4'd1;
  localparam logic [3:0] S_FA_REQ = 4'd2;
  localparam logic [3:0] S_FA_CHK = 4'd3;
  localparam logic [3:0] S_FB_CHK = 4'd4;
  localparam logic [3:0] S_UNION  = 4'd5;
  localparam logic [3:0] S_INC    = 4'd6;
  localparam logic [3:0] S_DONE   = 4'd7;

  logic [3:0] state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] sidx_r, sidx_nxt;
  logic pv_r, pv_nxt;
  logic [EAW-1:0] pidx_r, pidx_nxt;
  logic first_r, first_nxt;
  logic found_r, found_nxt;
  logic [KW-1:0] last_key_r, last_key_nxt;
  logic [KW-1:0] best_key_r, best_key_nxt;
  logic [VERT_BITS-1:0] best_a_r, best_a_nxt, best_b_r, best_b_nxt;
  logic [WEIGHT_BITS-1:0] best_w_r, best_w_nxt;
  logic [UFAW-1:0] xa_r, xa_nxt, ra_r, ra_nxt, rb_r, rb_nxt;
  logic [RANK_BITS-1:0] rka_r, rka_nxt, rkb_r, rkb_nxt;
  logic [UFD-1:0] vld_r, vld_nxt;
  logic signed [COST_BITS-1:0] cost_r, cost_nxt;
  logic [TAKE_BITS-1:0] taken_r, taken_nxt;
  logic out_valid_r, out_valid_nxt;
  logic signed [COST_BITS-1:0] out_cost_r, out_cost_nxt;
  logic [TAKE_BITS-1:0] out_taken_r, out_taken_nxt;

  // Edge memory ports
  logic e_we;
  logic [EAW-1:0] e_raddr;
  logic [EW-1:0] e_wdata, e_rdata;
  // Union-find memory ports
  logic u_we;
  logic [UFAW-1:0] u_waddr, u_raddr;
  uf_entry_t u_wdata, u_rdata;

  logic [31:0] w_ext;
  logic [WEIGHT_BITS-1:0] rd_w;
  logic [VERT_BITS-1:0] rd_a, rd_b;
  logic [KW-1:0] cur_key;
  logic [VERT_BITS-1:0] chk_par;
  logic [RANK_BITS-1:0] chk_rank;
  logic [SUM_BITS-1:0] sum;
  logic in_acc;

  assign in_ready        = (state_r == S_LOAD);
  assign in_acc          = in_valid && in_ready;
  assign out_valid       = out_valid_r;
  assign out_total_cost  = out_cost_r;
  assign out_edges_taken = out_taken_r;

  // Weight field is taken as raw bits, low WEIGHT_BITS kept.
  assign w_ext   = {16'b0, in_weight};
  assign e_wdata = {in_vertex_a, in_vertex_b, w_ext[WEIGHT_BITS-1:0]};
  assign e_we    = in_acc && (cnt_r < CW'(MAX_EDGES));

  assign {rd_a, rd_b, rd_w} = e_rdata;
  // Flip the sign bit so signed order becomes unsigned; arrival index breaks ties.
  assign cur_key = {~rd_w[WEIGHT_BITS-1], rd_w[WEIGHT_BITS-2:0], pidx_r};

  // An entry never written since the last clear reads as its own root, rank 0.
  assign chk_par  = vld_r[xa_r] ? u_rdata.parent : VERT_BITS'(xa_r);
  assign chk_rank = vld_r[xa_r] ? u_rdata.rank : '0;

  assign sum = SUM_BITS'(cost_r) + {{(SUM_BITS-WEIGHT_BITS){best_w_r[WEIGHT_BITS-1]}}, best_w_r};

  kmst_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edge_ram (
    .clk   (clk),
    .we    (e_we),
    .waddr (cnt_r[EAW-1:0]),
    .wdata (e_wdata),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  kmst_ram #(.WIDTH(UW), .DEPTH(UFD)) u_uf_ram (
    .clk   (clk),
    .we    (u_we),
    .waddr (u_waddr),
    .wdata (u_wdata),
    .raddr (u_raddr),
    .rdata (u_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    sidx_nxt      = sidx_r;
    pv_nxt        = 1'b0;
    pidx_nxt      = pidx_r;
    first_nxt     = first_r;
    found_nxt     = found_r;
    last_key_nxt  = last_key_r;
    best_key_nxt  = best_key_r;
    best_a_nxt    = best_a_r;
    best_b_nxt    = best_b_r;
    best_w_nxt    = best_w_r;
    xa_nxt        = xa_r;
    ra_nxt        = ra_r;
    rb_nxt        = rb_r;
    rka_nxt       = rka_r;
    rkb_nxt       = rkb_r;
    vld_nxt       = vld_r;
    cost_nxt      = cost_r;
    taken_nxt     = taken_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_cost_nxt  = out_cost_r;
    out_taken_nxt = out_taken_r;
    e_raddr       = sidx_r[EAW-1:0];
    u_we          = 1'b0;
    u_waddr       = ra_r;
    u_wdata       = '{parent: VERT_BITS'(ra_r), rank: rka_r};
    u_raddr       = xa_r;

    unique case (state_r)
      S_LOAD: begin
        if (in_acc) begin
          if (e_we) begin
            cnt_nxt = cnt_r + 1'b1;
          end
          if (in_last_edge) begin
            state_nxt = S_SCAN;
            sidx_nxt  = '0;
            found_nxt = 1'b0;
            first_nxt = 1'b1;
            cost_nxt  = '0;
            taken_nxt = '0;
          end
        end
      end
      S_SCAN: begin
        // Issue one read a cycle; judge the word that arrived from the last read.
        if (sidx_r < cnt_r) begin
          pv_nxt   = 1'b1;
          pidx_nxt = sidx_r[EAW-1:0];
          sidx_nxt = sidx_r + 1'b1;
        end
        if (pv_r && (first_r || cur_key > last_key_r) &&
            (!found_r || cur_key < best_key_r)) begin
          found_nxt    = 1'b1;
          best_key_nxt = cur_key;
          best_a_nxt   = rd_a;
          best_b_nxt   = rd_b;
          best_w_nxt   = rd_w;
        end
        if (!pv_r && sidx_r == cnt_r) begin
          if (!found_r) begin
            state_nxt = S_DONE;
          end else begin
            last_key_nxt = best_key_r;
            first_nxt    = 1'b0;
            sidx_nxt     = '0;
            found_nxt    = 1'b0;
            if (int'(best_a_r) >= MAX_VERTICES || int'(best_b_r) >= MAX_VERTICES) begin
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_FA_REQ;
            end
          end
        end
      end
      S_FA_REQ: begin
        u_raddr   = best_a_r[UFAW-1:0];
        xa_nxt    = best_a_r[UFAW-1:0];
        state_nxt = S_FA_CHK;
      end
      S_FA_CHK: begin
        if (chk_par == VERT_BITS'(xa_r)) begin
          ra_nxt    = xa_r;
          rka_nxt   = chk_rank;
          u_raddr   = best_b_r[UFAW-1:0];
          xa_nxt    = best_b_r[UFAW-1:0];
          state_nxt = S_FB_CHK;
        end else begin
          u_raddr = chk_par[UFAW-1:0];
          xa_nxt  = chk_par[UFAW-1:0];
        end
      end
      S_FB_CHK: begin
        if (chk_par == VERT_BITS'(xa_r)) begin
          rb_nxt    = xa_r;
          rkb_nxt   = chk_rank;
          state_nxt = S_UNION;
        end else begin
          u_raddr = chk_par[UFAW-1:0];
          xa_nxt  = chk_par[UFAW-1:0];
        end
      end
      S_UNION: begin
        state_nxt = S_SCAN;
        if (ra_r != rb_r) begin
          u_we = 1'b1;
          priority if (rka_r < rkb_r) begin
            u_waddr = ra_r;
            u_wdata = '{parent: VERT_BITS'(rb_r), rank: rka_r};
            vld_nxt[ra_r] = 1'b1;
          end else if (rka_r > rkb_r) begin
            u_waddr = rb_r;
            u_wdata = '{parent: VERT_BITS'(ra_r), rank: rkb_r};
            vld_nxt[rb_r] = 1'b1;
          end else begin
            u_waddr = rb_r;
            u_wdata = '{parent: VERT_BITS'(ra_r), rank: rkb_r};
            vld_nxt[rb_r] = 1'b1;
            state_nxt = S_INC;
          end
          // Saturate the running cost and the edge tally.
          priority if ($signed(sum) > $signed(COST_MAX)) begin
            cost_nxt = COST_BITS'(COST_MAX);
          end else if ($signed(sum) < $signed(COST_MIN)) begin
            cost_nxt = COST_BITS'(COST_MIN);
          end else begin
            cost_nxt = sum[COST_BITS-1:0];
          end
          if (taken_r != TAKE_TOP) begin
            taken_nxt = taken_r + 1'b1;
          end
        end
      end
      S_INC: begin
        u_we    = 1'b1;
        u_waddr = ra_r;
        u_wdata = '{parent: VERT_BITS'(ra_r),
                    rank: (rka_r == RANK_TOP) ? rka_r : rka_r + 1'b1};
        vld_nxt[ra_r] = 1'b1;
        state_nxt = S_SCAN;
      end
      S_DONE: begin
        // Hold until the output register is free, then drop back to loading.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_cost_nxt  = cost_r;
          out_taken_nxt = taken_r;
          vld_nxt       = '0;
          cnt_nxt       = '0;
          state_nxt     = S_LOAD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      pv_r        <= 1'b0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pv_r        <= pv_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sidx_r      <= sidx_nxt;
    pidx_r      <= pidx_nxt;
    first_r     <= first_nxt;
    found_r     <= found_nxt;
    last_key_r  <= last_key_nxt;
    best_key_r  <= best_key_nxt;
    best_a_r    <= best_a_nxt;
    best_b_r    <= best_b_nxt;
    best_w_r    <= best_w_nxt;
    xa_r        <= xa_nxt;
    ra_r        <= ra_nxt;
    rb_r        <= rb_nxt;
    rka_r       <= rka_nxt;
    rkb_r       <= rkb_nxt;
    cost_r      <= cost_nxt;
    taken_r     <= taken_nxt;
    out_cost_r  <= out_cost_nxt;
    out_taken_r <= out_taken_nxt;
  end

endmodule

>>> sv/kmst_ram.sv
module kmst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> tb/kruskal_mst_cost_tb.sv
`timescale 1ns / 1ps

module kruskal_mst_cost_tb;
  import kmst_pkg::*;

  localparam int N_EDGES    = DEF_MAX_EDGES;
  localparam int N_VERTS    = DEF_MAX_VERTICES;
  localparam int IDLE_LIMIT = 400000;
  localparam int TAIL_WAIT  = 200;
  localparam logic signed [COST_BITS-1:0] SAT_HI = 24'sh7FFFFF;
  localparam logic signed [COST_BITS-1:0] SAT_LO = 24'sh800000;

  typedef struct {
    logic [VERT_BITS-1:0]        a;
    logic [VERT_BITS-1:0]        b;
    logic signed [IN_W_BITS-1:0] w;
  } edge_word_t;

  typedef struct {
    logic signed [COST_BITS-1:0] cost;
    logic [TAKE_BITS-1:0]        taken;
  } forest_sum_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [VERT_BITS-1:0] in_vertex_a = '0;
  logic [VERT_BITS-1:0] in_vertex_b = '0;
  logic signed [IN_W_BITS-1:0] in_weight = '0;
  logic in_last_edge = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [COST_BITS-1:0] out_total_cost;
  logic [TAKE_BITS-1:0] out_edges_taken;

  // graph being loaded, and forest sums still owed by the block
  edge_word_t  open_graph[$];
  forest_sum_t forest_q[$];

  int  fail_count = 0;
  int  idle_cycles = 0;
  bit  quiet = 1'b0;   // set for the closing stretch: no idling either side
  int  stall_left = 0;

  always #5 clk = ~clk;

  kruskal_mst_cost DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .in_weight(in_weight), .in_last_edge(in_last_edge),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_total_cost(out_total_cost), .out_edges_taken(out_edges_taken)
  );

  // Kruskal over the closed graph: stable sort by weight, then union-find
  // with path compression and union by rank; saturate the running sum.
  function automatic forest_sum_t mst_of_graph(edge_word_t g[$]);
    edge_word_t  s[$];
    edge_word_t  e;
    int          parent[N_VERTS];
    int          rnk[N_VERTS];
    int          j, ra, rb, x, nx;
    longint      sum;
    int          taken;
    forest_sum_t r;
    s = g;
    for (int i = 1; i < s.size(); i++) begin
      e = s[i];
      j = i;
      while (j > 0 && s[j-1].w > e.w) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = e;
    end
    for (int v = 0; v < N_VERTS; v++) begin
      parent[v] = v;
      rnk[v] = 0;
    end
    sum = 0;
    taken = 0;
    foreach (s[i]) begin
      ra = s[i].a;
      while (parent[ra] != ra) ra = parent[ra];
      x = s[i].a;
      while (parent[x] != ra) begin
        nx = parent[x];
        parent[x] = ra;
        x = nx;
      end
      rb = s[i].b;
      while (parent[rb] != rb) rb = parent[rb];
      x = s[i].b;
      while (parent[x] != rb) begin
        nx = parent[x];
        parent[x] = rb;
        x = nx;
      end
      if (ra == rb) continue;
      if (rnk[ra] < rnk[rb]) begin
        parent[ra] = rb;
      end else if (rnk[ra] > rnk[rb]) begin
        parent[rb] = ra;
      end else begin
        parent[rb] = ra;
        if (rnk[ra] < 15) rnk[ra]++;
      end
      sum += s[i].w;
      if (sum > longint'(SAT_HI)) sum = SAT_HI;
      if (sum < longint'(SAT_LO)) sum = SAT_LO;
      if (taken < 255) taken++;
    end
    r.cost  = sum[COST_BITS-1:0];
    r.taken = taken[TAKE_BITS-1:0];
    return r;
  endfunction

  // Offer one edge word; hold it until accepted, then record it.
  task automatic send_edge(input logic [7:0] a, input logic [7:0] b,
                           input logic signed [15:0] w, input bit last);
    edge_word_t e;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_vertex_a  <= a;
    in_vertex_b  <= b;
    in_weight    <= w;
    in_last_edge <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e.a = a;
    e.b = b;
    e.w = w;
    // drop words arriving once the store is full
    if (open_graph.size() < N_EDGES) open_graph.push_back(e);
    if (last) begin
      forest_q.push_back(mst_of_graph(open_graph));
      open_graph.delete();
    end
  endtask

  // Sink side: random stall bursts, compare each word, run the watchdog.
  always @(posedge clk) begin
    forest_sum_t exp_sum;
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid && out_ready) begin
        if (forest_q.size() == 0) begin
          $error("unexpected result word: total_cost %0d edges_taken %0d",
                 out_total_cost, out_edges_taken);
          fail_count++;
        end else begin
          exp_sum = forest_q.pop_front();
          if (out_total_cost !== exp_sum.cost) begin
            $error("total_cost expected %0d actual %0d", exp_sum.cost, out_total_cost);
            fail_count++;
          end
          if (out_edges_taken !== exp_sum.taken) begin
            $error("edges_taken expected %0d actual %0d", exp_sum.taken, out_edges_taken);
            fail_count++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(1, 19) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Extremes of every field, self loops, ties and tiny graphs.
  task automatic test_directed();
    send_edge(8'd0, 8'd0, 16'sd5, 1'b1);              // lone self loop
    send_edge(8'd0, 8'd255, -16'sd32768, 1'b1);       // single edge, lowest weight
    send_edge(8'd255, 8'd0, 16'sd32767, 1'b1);        // single edge, highest weight
    send_edge(8'd1, 8'd2, 16'sd7, 1'b0);              // triangle with a tie
    send_edge(8'd2, 8'd3, 16'sd7, 1'b0);
    send_edge(8'd3, 8'd1, 16'sd7, 1'b1);
    send_edge(8'd10, 8'd11, 16'sd4, 1'b0);            // heavier duplicate dropped
    send_edge(8'd11, 8'd10, 16'sd9, 1'b0);
    send_edge(8'd12, 8'd12, -16'sd100, 1'b0);
    send_edge(8'd11, 8'd12, -16'sd1, 1'b1);
    send_edge(8'd170, 8'd85, 16'sh5555, 1'b0);        // disjoint forest
    send_edge(8'd85, 8'd170, -16'sd2, 1'b0);
    send_edge(8'd200, 8'd201, 16'sh2AAA, 1'b0);
    send_edge(8'd254, 8'd255, 16'sd0, 1'b1);
  endtask

  // Overfill the store; the words past the limit are dropped, last included.
  task automatic test_store_full();
    for (int i = 0; i < N_EDGES + 3; i++)
      send_edge(8'($urandom), 8'($urandom), 16'($urandom), i == N_EDGES + 2);
  endtask

  // Random graphs: mostly small, over a narrow or the full vertex range.
  task automatic test_random_graphs(input int n_words);
    int sent, len, span;
    sent = 0;
    while (sent < n_words) begin
      if (n_words - sent < 200) quiet = 1'b1;
      len  = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
      span = ($urandom_range(0, 1) == 0) ? 15 : 255;
      for (int i = 0; i < len; i++) begin
        send_edge(8'($urandom_range(0, span)), 8'($urandom_range(0, span)),
                  ($urandom_range(0, 3) == 0) ? 16'($urandom)
                                              : 16'($signed($urandom_range(0, 64)) - 32),
                  i == len - 1);
      end
      sent += len;
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random_graphs(1130);
    in_valid <= 1'b0;
    while (forest_q.size() != 0) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
sv/kmst_pkg.sv
sv/kmst_ram.sv
sv/kruskal_mst_cost.sv
tb/kruskal_mst_cost_tb.sv
